FILE: sv/nirs_pkg.sv
// ----------------------------------------------------------------------------
// nirs_pkg
// Shared types and constants of the NEC-style infrared frame segmenter.
// ----------------------------------------------------------------------------
package nirs_pkg;

  // output count fields are always this wide
  localparam int unsigned CntW = 10;
  localparam int unsigned CountBitsDef = 10;

  localparam int unsigned LeaderMarkRst  = 342;
  localparam int unsigned LeaderSpaceRst = 171;
  localparam int unsigned BitMarkRst     = 21;
  localparam int unsigned ZeroSpaceRst   = 21;
  localparam int unsigned OneSpaceRst    = 60;
  localparam logic [1:0]  StopCountRst   = 2'd2;

  typedef enum logic [2:0] {
    CFG_LEADER_MARK  = 3'd0,
    CFG_LEADER_SPACE = 3'd1,
    CFG_BIT_MARK     = 3'd2,
    CFG_ZERO_SPACE   = 3'd3,
    CFG_ONE_SPACE    = 3'd4,
    CFG_STOP_COUNT   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_LEADER = 2'd0,
    KIND_ZERO   = 2'd1,
    KIND_ONE    = 2'd2,
    KIND_STOP   = 2'd3
  } seg_kind_e;

  // live register values, already narrowed to the output field width
  typedef struct packed {
    logic [CntW-1:0] leader_mark;
    logic [CntW-1:0] leader_space;
    logic [CntW-1:0] bit_mark;
    logic [CntW-1:0] zero_space;
    logic [CntW-1:0] one_space;
    logic [1:0]      stop_count;
  } cfg_t;

  // one classified byte handed from front to back
  typedef struct packed {
    logic        leader;
    logic        last;
    logic [15:0] word;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] mark;
    logic [CntW-1:0] space;
    seg_kind_e       kind;
    logic            end_of_run;
    logic            end_of_frame;
  } seg_t;

endpackage

FILE: sv/nec_ir_frame_segmenter.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_segmenter
// Turns frame bytes into NEC-style mark/space pulse segments.
// ----------------------------------------------------------------------------
// Each byte pushed in yields 16 to 20 segments: a leader when no frame is
// open, sixteen data segments (the byte, then its complement, lsb first) and,
// after a byte flagged last, stop_count stop segments. The segment sequencer
// emits one segment per clock while the result queue has room; a two-deep
// command queue lets the next bytes be taken in while the current one is
// expanded, and a two-deep result queue absorbs stalls on pop. The user must
// write configuration only while the block is idle; the block itself does
// not enforce this.
module nec_ir_frame_segmenter #(
  parameter int unsigned COUNT_BITS = nirs_pkg::CountBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [2:0]                cfg_idx_i,
  input  logic [COUNT_BITS-1:0]     cfg_wdata_i,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      last_byte_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [nirs_pkg::CntW-1:0] mark_periods_o,
  output logic [nirs_pkg::CntW-1:0] space_periods_o,
  output logic [1:0]                segment_kind_o,
  output logic                      end_of_run_o,
  output logic                      end_of_frame_o
);

  nirs_pkg::cfg_t cfg;
  nirs_pkg::cmd_t cmd;
  logic           cmd_valid, cmd_take;

  nirs_cfg #(
    .COUNT_BITS(COUNT_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  nirs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  nirs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_take_o      (cmd_take),
    .empty_o         (empty_o),
    .pop_i           (pop_i),
    .mark_periods_o  (mark_periods_o),
    .space_periods_o (space_periods_o),
    .segment_kind_o  (segment_kind_o),
    .end_of_run_o    (end_of_run_o),
    .end_of_frame_o  (end_of_frame_o)
  );

endmodule

FILE: sv/nirs_cfg.sv
// ----------------------------------------------------------------------------
// nirs_cfg
// Configuration register file: timing counts and stop segment count.
// ----------------------------------------------------------------------------
module nirs_cfg #(
  parameter int unsigned COUNT_BITS = nirs_pkg::CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [COUNT_BITS-1:0] cfg_wdata_i,
  output nirs_pkg::cfg_t        cfg_o
);

  localparam int unsigned CW = nirs_pkg::CntW;

  logic [COUNT_BITS-1:0] leader_mark_q, leader_space_q, bit_mark_q;
  logic [COUNT_BITS-1:0] zero_space_q, one_space_q;
  logic [1:0]            stop_count_q;

  function automatic logic [CW-1:0] narrow(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+CW-1:0] w;
    w = {{CW{1'b0}}, v};
    return w[CW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leader_mark_q  <= COUNT_BITS'(nirs_pkg::LeaderMarkRst);
      leader_space_q <= COUNT_BITS'(nirs_pkg::LeaderSpaceRst);
      bit_mark_q     <= COUNT_BITS'(nirs_pkg::BitMarkRst);
      zero_space_q   <= COUNT_BITS'(nirs_pkg::ZeroSpaceRst);
      one_space_q    <= COUNT_BITS'(nirs_pkg::OneSpaceRst);
      stop_count_q   <= nirs_pkg::StopCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nirs_pkg::CFG_LEADER_MARK:  leader_mark_q  <= cfg_wdata_i;
        nirs_pkg::CFG_LEADER_SPACE: leader_space_q <= cfg_wdata_i;
        nirs_pkg::CFG_BIT_MARK:     bit_mark_q     <= cfg_wdata_i;
        nirs_pkg::CFG_ZERO_SPACE:   zero_space_q   <= cfg_wdata_i;
        nirs_pkg::CFG_ONE_SPACE:    one_space_q    <= cfg_wdata_i;
        nirs_pkg::CFG_STOP_COUNT:   stop_count_q   <= cfg_wdata_i[1:0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  assign cfg_o.leader_mark  = narrow(leader_mark_q);
  assign cfg_o.leader_space = narrow(leader_space_q);
  assign cfg_o.bit_mark     = narrow(bit_mark_q);
  assign cfg_o.zero_space   = narrow(zero_space_q);
  assign cfg_o.one_space    = narrow(one_space_q);
  assign cfg_o.stop_count   = stop_count_q;

endmodule

FILE: sv/nirs_front.sv
// ----------------------------------------------------------------------------
// nirs_front
// Accepts bytes, decides whether a leader is due and queues the commands.
// ----------------------------------------------------------------------------
module nirs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output logic           cmd_valid_o,
  output nirs_pkg::cmd_t cmd_o,
  input  logic           cmd_take_i
);

  logic           in_frame_q;
  nirs_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           accept, take;
  nirs_pkg::cmd_t new_cmd;

  assign full_o      = (cnt_q == 2'd2);
  assign accept      = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign take        = cmd_take_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    new_cmd.leader = !in_frame_q;
    new_cmd.last   = last_byte_i;
    // byte then its complement, both sent lsb first
    new_cmd.word   = {~data_byte_i, data_byte_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
      cnt_q      <= 2'd0;
    end else begin
      if (accept) begin
        in_frame_q <= !last_byte_i;
        wr_ptr_q   <= !wr_ptr_q;
      end
      if (take) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(accept) - 2'(take);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

FILE: sv/nirs_back.sv
// ----------------------------------------------------------------------------
// nirs_back
// Segment sequencer: expands one command into leader, data and stop segments,
// one a cycle while the result queue has room, into a two-entry result queue.
// ----------------------------------------------------------------------------
module nirs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nirs_pkg::cfg_t                cfg_i,
  input  logic                          cmd_valid_i,
  input  nirs_pkg::cmd_t                cmd_i,
  output logic                          cmd_take_o,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [nirs_pkg::CntW-1:0]     mark_periods_o,
  output logic [nirs_pkg::CntW-1:0]     space_periods_o,
  output logic [1:0]                    segment_kind_o,
  output logic                          end_of_run_o,
  output logic                          end_of_frame_o
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_LEADER = 4'b0010,
    PH_DATA   = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [3:0]     bit_idx_q, bit_idx_d;
  logic [1:0]     stop_left_q, stop_left_d;
  logic [15:0]    word_q;
  logic           last_q;

  nirs_pkg::seg_t seg;
  nirs_pkg::seg_t oq_q [2];
  logic           owr_q, ord_q;
  logic [1:0]     ocnt_q;
  logic           pop_ok, room, emit, last_bit, stops_due;

  assign last_bit  = (bit_idx_q == 4'd15);
  assign stops_due = last_q && (cfg_i.stop_count != 2'd0);

  always_comb begin
    seg.mark         = '0;
    seg.space        = '0;
    seg.kind         = nirs_pkg::KIND_LEADER;
    seg.end_of_run   = 1'b0;
    seg.end_of_frame = 1'b0;
    unique case (phase_q)
      PH_LEADER: begin
        seg.mark  = cfg_i.leader_mark;
        seg.space = cfg_i.leader_space;
      end
      PH_DATA: begin
        seg.mark = cfg_i.bit_mark;
        if (word_q[bit_idx_q]) begin
          seg.space = cfg_i.one_space;
          seg.kind  = nirs_pkg::KIND_ONE;
        end else begin
          seg.space = cfg_i.zero_space;
          seg.kind  = nirs_pkg::KIND_ZERO;
        end
        seg.end_of_run   = last_bit && !stops_due;
        seg.end_of_frame = last_bit && last_q && !stops_due;
      end
      PH_STOP: begin
        seg.mark         = cfg_i.bit_mark;
        seg.space        = cfg_i.zero_space;
        seg.kind         = nirs_pkg::KIND_STOP;
        seg.end_of_run   = (stop_left_q == 2'd0);
        seg.end_of_frame = (stop_left_q == 2'd0);
      end
      default: ;
    endcase
  end

  assign pop_ok = pop_i && !empty_o;
  assign room   = (ocnt_q != 2'd2) || pop_ok;
  assign emit   = (phase_q != PH_IDLE) && room;
  // next command loads in the cycle the current one emits its final segment
  assign cmd_take_o = cmd_valid_i && ((phase_q == PH_IDLE) || (emit && seg.end_of_run));

  always_comb begin
    phase_d     = phase_q;
    bit_idx_d   = bit_idx_q;
    stop_left_d = stop_left_q;
    if (emit) begin
      unique case (phase_q)
        PH_LEADER: begin
          phase_d   = PH_DATA;
          bit_idx_d = 4'd0;
        end
        PH_DATA: begin
          if (!last_bit) begin
            bit_idx_d = bit_idx_q + 4'd1;
          end else if (stops_due) begin
            phase_d     = PH_STOP;
            stop_left_d = cfg_i.stop_count - 2'd1;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_STOP: begin
          if (stop_left_q == 2'd0) begin
            phase_d = PH_IDLE;
          end else begin
            stop_left_d = stop_left_q - 2'd1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_take_o) begin
      phase_d   = cmd_i.leader ? PH_LEADER : PH_DATA;
      bit_idx_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_idx_q   <= 4'd0;
      stop_left_q <= 2'd0;
      owr_q       <= 1'b0;
      ord_q       <= 1'b0;
      ocnt_q      <= 2'd0;
    end else begin
      phase_q     <= phase_d;
      bit_idx_q   <= bit_idx_d;
      stop_left_q <= stop_left_d;
      if (emit) begin
        owr_q <= !owr_q;
      end
      if (pop_ok) begin
        ord_q <= !ord_q;
      end
      ocnt_q <= ocnt_q + 2'(emit) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      word_q <= cmd_i.word;
      last_q <= cmd_i.last;
    end
    if (emit) begin
      oq_q[owr_q] <= seg;
    end
  end

  assign empty_o         = (ocnt_q == 2'd0);
  assign mark_periods_o  = oq_q[ord_q].mark;
  assign space_periods_o = oq_q[ord_q].space;
  assign segment_kind_o  = oq_q[ord_q].kind;
  assign end_of_run_o    = oq_q[ord_q].end_of_run;
  assign end_of_frame_o  = oq_q[ord_q].end_of_frame;

endmodule

FILE: sv/nirs_checker.sv
// ----------------------------------------------------------------------------
// nirs_checker
// Port-level checks on the segment stream of the frame segmenter.
// ----------------------------------------------------------------------------
module nirs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      empty_o,
  input logic                      pop_i,
  input logic [nirs_pkg::CntW-1:0] mark_periods_o,
  input logic [nirs_pkg::CntW-1:0] space_periods_o,
  input logic [1:0]                segment_kind_o,
  input logic                      end_of_run_o,
  input logic                      end_of_frame_o
);

  // a leader segment never closes a run
  a_leader_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && segment_kind_o == nirs_pkg::KIND_LEADER) |-> !end_of_run_o)
    else $error("leader segment closes a run");

  a_frame_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && end_of_frame_o) |-> end_of_run_o)
    else $error("end of frame without end of run");

  // after a popped stop that does not end the run, the next beat, if any, is a stop
  a_stop_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && segment_kind_o == nirs_pkg::KIND_STOP && !end_of_run_o)
    |=> (empty_o || segment_kind_o == nirs_pkg::KIND_STOP))
    else $error("stop group broken");

  a_hold_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(mark_periods_o)
      && $stable(space_periods_o) && $stable(segment_kind_o)
      && $stable(end_of_run_o) && $stable(end_of_frame_o)))
    else $error("waiting beat changed");

endmodule

bind nec_ir_frame_segmenter nirs_checker u_nirs_checker (.*);
